// File: hw/rtl/rc4rg_pkg.sv
// Shared types and codes for the RC4 random generator.
package rc4rg_pkg;

   localparam logic [2:0] CMD_KEY   = 3'd0;
   localparam logic [2:0] CMD_STIR  = 3'd1;
   localparam logic [2:0] CMD_BYTE  = 3'd2;
   localparam logic [2:0] CMD_WORD  = 3'd3;
   localparam logic [2:0] CMD_BOUND = 3'd4;

   localparam logic [4:0] OP_NOP        = 5'd0;
   localparam logic [4:0] OP_INIT       = 5'd1;
   localparam logic [4:0] OP_SEED_ID    = 5'd2;
   localparam logic [4:0] OP_PASS_START = 5'd3;
   localparam logic [4:0] OP_RI         = 5'd4;
   localparam logic [4:0] OP_RJ         = 5'd5;
   localparam logic [4:0] OP_WI         = 5'd6;
   localparam logic [4:0] OP_WJ         = 5'd7;
   localparam logic [4:0] OP_PASS_END   = 5'd8;
   localparam logic [4:0] OP_RO         = 5'd9;
   localparam logic [4:0] OP_CAP        = 5'd10;
   localparam logic [4:0] OP_RELOAD     = 5'd11;
   localparam logic [4:0] OP_DEC1       = 5'd12;
   localparam logic [4:0] OP_DEC4       = 5'd13;
   localparam logic [4:0] OP_KEY_WR     = 5'd14;
   localparam logic [4:0] OP_KEY_CLR    = 5'd15;
   localparam logic [4:0] OP_WCLR       = 5'd16;
   localparam logic [4:0] OP_DIV_LIM    = 5'd17;
   localparam logic [4:0] OP_DIV_MOD    = 5'd18;
   localparam logic [4:0] OP_RES_WORD   = 5'd19;
   localparam logic [4:0] OP_RES_REM    = 5'd20;
   localparam logic [4:0] OP_RES_ZERO   = 5'd21;

   localparam logic [1:0] CSR_RESEED = 2'd0;
   localparam logic [1:0] CSR_SEED   = 2'd1;

   localparam logic [23:0] RESEED_RESET = 24'd1600000;

   typedef struct packed {
      logic [4:0] op;
      logic [7:0] cnt;
      logic       mix;
      logic       kmode;
   } dp_cmd_type;

   typedef struct packed {
      logic seeded;
      logic le1;
      logic le4;
      logic bound_small;
      logic rej;
      logic div_busy;
   } dp_status_type;

endpackage

// File: hw/rtl/rc4rg_divider.sv
// Restoring remainder unit, one quotient bit per cycle.
module rc4rg_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] remainder
);
   logic [32:0] rem_ff, rem_in;
   logic [32:0] dvd_ff, dvd_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[31:0], dvd_ff[32]};
      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
         end else begin
            rem_in = trial;
         end
         dvd_in = {dvd_ff[31:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff[31:0];
endmodule

// File: hw/rtl/rc4rg_datapath.sv
// Permutation table, key store, indices, countdown and result assembly.
module rc4rg_datapath
   import rc4rg_pkg::*;
#(
   parameter int KEY_BYTES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [7:0]    key_byte,
   input  logic [31:0]   bound_limit,
   input  logic [23:0]   reseed_interval,
   input  logic [31:0]   stir_seed,
   output dp_status_type status,
   output logic [31:0]   result
);
   localparam int KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int KCNT_W = $clog2(KEY_BYTES + 1);
   localparam logic [KCNT_W-1:0] KeyMax = KCNT_W'(KEY_BYTES);

   logic [7:0] perm_mem [256];
   logic [7:0] key_mem [KEY_BYTES];

   logic [7:0]  i_ff, i_in, j_ff, j_in, si_ff, si_in, sj_ff, sj_in;
   logic [7:0]  rd_ff, key_rd_ff;
   logic [31:0] word_ff, word_in, result_ff, result_in;
   logic [23:0] left_ff, left_in;
   logic        seeded_ff, seeded_in;
   logic [KCNT_W-1:0] kcnt_ff, kcnt_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;

   logic       rd_en, wr_en, key_wr_en;
   logic [7:0] rd_addr, wr_addr, wr_data, key_term, seed_byte, j_new;
   logic       div_start, div_busy;
   logic [32:0] div_dividend;
   logic [31:0] div_rem;

   always_comb begin
      unique case (cmd.cnt[1:0])
         2'd0: seed_byte = stir_seed[7:0];
         2'd1: seed_byte = stir_seed[15:8];
         2'd2: seed_byte = stir_seed[23:16];
         default: seed_byte = stir_seed[31:24];
      endcase
      if (cmd.cnt[6:2] != 5'd0) begin
         seed_byte = 8'd0;
      end
      key_term = cmd.mix ? (cmd.kmode ? key_rd_ff : seed_byte) : 8'd0;
      j_new    = j_ff + rd_ff + key_term;
   end

   always_comb begin
      i_in = i_ff; j_in = j_ff; si_in = si_ff; sj_in = sj_ff;
      word_in = word_ff; result_in = result_ff; left_in = left_ff;
      seeded_in = seeded_ff; kcnt_in = kcnt_ff; kidx_in = kidx_ff;
      rd_en = 1'b0; rd_addr = i_ff;
      wr_en = 1'b0; wr_addr = i_ff; wr_data = rd_ff;
      key_wr_en = 1'b0;
      div_start = 1'b0; div_dividend = {1'b0, word_ff};
      unique case (cmd.op)
         OP_INIT: begin
            wr_en = 1'b1; wr_addr = cmd.cnt; wr_data = cmd.cnt;
         end
         OP_SEED_ID: begin
            i_in = 8'd0; j_in = 8'd0; seeded_in = 1'b1;
         end
         OP_PASS_START: begin
            i_in = i_ff - 8'd1; kidx_in = '0;
         end
         OP_RI: begin
            i_in = i_ff + 8'd1; rd_en = 1'b1; rd_addr = i_ff + 8'd1;
         end
         OP_RJ: begin
            si_in = rd_ff; j_in = j_new; rd_en = 1'b1; rd_addr = j_new;
            if (cmd.mix && cmd.kmode) begin
               if (({1'b0, kidx_ff} + (KIDX_W+1)'(1)) == (KIDX_W+1)'(kcnt_ff)) begin
                  kidx_in = '0;
               end else begin
                  kidx_in = kidx_ff + KIDX_W'(1);
               end
            end
         end
         OP_WI: begin
            sj_in = rd_ff; wr_en = 1'b1; wr_addr = i_ff; wr_data = rd_ff;
         end
         OP_WJ: begin
            wr_en = 1'b1; wr_addr = j_ff; wr_data = si_ff;
         end
         OP_PASS_END: j_in = i_ff;
         OP_RO: begin
            rd_en = 1'b1; rd_addr = si_ff + sj_ff;
         end
         OP_CAP:    word_in = {word_ff[23:0], rd_ff};
         OP_RELOAD: left_in = reseed_interval;
         OP_DEC1:   left_in = left_ff - 24'd1;
         OP_DEC4:   left_in = left_ff - 24'd4;
         OP_KEY_WR: begin
            if (kcnt_ff < KeyMax) begin
               key_wr_en = 1'b1;
               kcnt_in   = kcnt_ff + KCNT_W'(1);
            end
         end
         OP_KEY_CLR: kcnt_in = '0;
         OP_WCLR:    word_in = '0;
         OP_DIV_LIM: begin
            div_start = 1'b1; div_dividend = 33'h1_0000_0000;
         end
         OP_DIV_MOD: div_start = 1'b1;
         OP_RES_WORD: result_in = word_ff;
         OP_RES_REM:  result_in = div_rem;
         OP_RES_ZERO: result_in = '0;
         default: ;
      endcase
   end

   // During a key pass the key entry for the step is fetched with the i read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= perm_mem[rd_addr];
      end
      if (key_wr_en) begin
         key_mem[kcnt_ff[KIDX_W-1:0]] <= key_byte;
      end
      if (cmd.op == OP_RI) begin
         key_rd_ff <= key_mem[kidx_ff];
      end
   end

   always_ff @(posedge clock) begin
      si_ff     <= si_in;
      sj_ff     <= sj_in;
      word_ff   <= word_in;
      result_ff <= result_in;
      kidx_ff   <= kidx_in;
      if (reset) begin
         i_ff      <= 8'd0;
         j_ff      <= 8'd0;
         left_ff   <= 24'd0;
         seeded_ff <= 1'b0;
         kcnt_ff   <= '0;
      end else begin
         i_ff      <= i_in;
         j_ff      <= j_in;
         left_ff   <= left_in;
         seeded_ff <= seeded_in;
         kcnt_ff   <= kcnt_in;
      end
   end

   rc4rg_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (bound_limit),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   assign status.seeded      = seeded_ff;
   assign status.le1         = (left_ff <= 24'd1);
   assign status.le4         = (left_ff <= 24'd4);
   assign status.bound_small = (bound_limit < 32'd2);
   assign status.rej         = (word_ff < div_rem);
   assign status.div_busy    = div_busy;
   assign result             = result_ff;
endmodule

// File: hw/rtl/rc4rg_controller.sv
// Sequencer that drives the datapath through stirs, passes and outputs.
module rc4rg_controller
   import rc4rg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2:0]    cmd,
   input  logic          key_last,
   input  logic          out_free,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd,
   output logic          idle,
   output logic          done
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_DISP = 5'd1,  S_KEYCHK = 5'd2, S_KMIX = 5'd3,
                          S_STIR = 5'd4,  S_INIT = 5'd5,  S_SEEDID = 5'd6, S_PSTART = 5'd7,
                          S_RI = 5'd8,    S_RJ = 5'd9,    S_WI = 5'd10,    S_WJ = 5'd11,
                          S_PEND = 5'd12, S_RELOAD = 5'd13, S_RO = 5'd14,  S_CAP = 5'd15,
                          S_RW = 5'd16,   S_BCHK = 5'd17, S_BGEN = 5'd18,  S_WCHK = 5'd19,
                          S_WGEN = 5'd20, S_REJ = 5'd21,  S_LIMWAIT = 5'd22,
                          S_MODWAIT = 5'd23, S_KEND = 5'd24, S_RZ = 5'd25, S_DONE = 5'd26;

   localparam logic [1:0] P_MIX = 2'd0, P_DISC = 2'd1, P_OUT = 2'd2;
   localparam logic [1:0] R_ZERO = 2'd0, R_KEYMIX = 2'd1, R_BYTE = 2'd2, R_WORD = 2'd3;

   logic [4:0] state_ff, state_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [1:0] bcnt_ff, bcnt_in, phase_ff, phase_in, ret_ff, ret_in;
   logic       kmode_ff, kmode_in;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; bcnt_in = bcnt_ff;
      phase_in = phase_ff; ret_in = ret_ff; kmode_in = kmode_ff;
      dp_cmd.op    = OP_NOP;
      dp_cmd.cnt   = cnt_ff;
      dp_cmd.mix   = (phase_ff == P_MIX);
      dp_cmd.kmode = kmode_ff;
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_DISP;
         S_DISP: begin
            unique case (cmd)
               CMD_KEY: begin
                  dp_cmd.op = OP_KEY_WR; state_in = S_KEYCHK;
               end
               CMD_STIR: begin
                  ret_in = R_ZERO; state_in = S_STIR;
               end
               CMD_BYTE: state_in = S_BCHK;
               CMD_WORD: state_in = S_WCHK;
               CMD_BOUND: begin
                  if (status.bound_small) begin
                     dp_cmd.op = OP_RES_ZERO; state_in = S_DONE;
                  end else begin
                     dp_cmd.op = OP_DIV_LIM; state_in = S_LIMWAIT;
                  end
               end
               default: begin
                  dp_cmd.op = OP_RES_ZERO; state_in = S_DONE;
               end
            endcase
         end
         S_KEYCHK: begin
            if (!key_last) begin
               state_in = S_RZ;
            end else if (!status.seeded) begin
               ret_in = R_KEYMIX; state_in = S_STIR;
            end else begin
               state_in = S_KMIX;
            end
         end
         S_KMIX: begin
            kmode_in = 1'b1; state_in = S_PSTART;
         end
         S_STIR: begin
            kmode_in = 1'b0; cnt_in = 8'd0;
            state_in = status.seeded ? S_PSTART : S_INIT;
         end
         S_INIT: begin
            dp_cmd.op = OP_INIT; cnt_in = cnt_ff + 8'd1;
            if (cnt_ff == 8'd255) state_in = S_SEEDID;
         end
         S_SEEDID: begin
            dp_cmd.op = OP_SEED_ID; state_in = S_PSTART;
         end
         S_PSTART: begin
            dp_cmd.op = OP_PASS_START; cnt_in = 8'd0; phase_in = P_MIX; state_in = S_RI;
         end
         S_RI: begin
            dp_cmd.op = OP_RI; state_in = S_RJ;
         end
         S_RJ: begin
            dp_cmd.op = OP_RJ; state_in = S_WI;
         end
         S_WI: begin
            dp_cmd.op = OP_WI; state_in = S_WJ;
         end
         S_WJ: begin
            dp_cmd.op = OP_WJ;
            cnt_in = cnt_ff + 8'd1;
            unique case (phase_ff)
               P_MIX:  state_in = (cnt_ff == 8'd255) ? S_PEND : S_RI;
               P_DISC: state_in = (cnt_ff == 8'd255) ? S_RELOAD : S_RI;
               default: state_in = S_RO;
            endcase
         end
         S_PEND: begin
            dp_cmd.op = OP_PASS_END;
            if (kmode_ff) begin
               state_in = S_KEND;
            end else begin
               phase_in = P_DISC; cnt_in = 8'd0; state_in = S_RI;
            end
         end
         S_RELOAD: begin
            dp_cmd.op = OP_RELOAD;
            unique case (ret_ff)
               R_ZERO:   state_in = S_RZ;
               R_KEYMIX: state_in = S_KMIX;
               R_BYTE:   state_in = S_BGEN;
               default:  state_in = S_WGEN;
            endcase
         end
         S_RO: begin
            dp_cmd.op = OP_RO; state_in = S_CAP;
         end
         S_CAP: begin
            dp_cmd.op = OP_CAP;
            if (bcnt_ff != 2'd0) begin
               bcnt_in = bcnt_ff - 2'd1; state_in = S_RI;
            end else if (cmd == CMD_BOUND) begin
               state_in = S_REJ;
            end else begin
               state_in = S_RW;
            end
         end
         S_RW: begin
            dp_cmd.op = OP_RES_WORD; state_in = S_DONE;
         end
         S_BCHK: begin
            if (!status.seeded || status.le1) begin
               ret_in = R_BYTE; state_in = S_STIR;
            end else begin
               dp_cmd.op = OP_DEC1; state_in = S_BGEN;
            end
         end
         S_BGEN: begin
            dp_cmd.op = OP_WCLR; bcnt_in = 2'd0; phase_in = P_OUT; state_in = S_RI;
         end
         S_WCHK: begin
            if (!status.seeded || status.le4) begin
               ret_in = R_WORD; state_in = S_STIR;
            end else begin
               dp_cmd.op = OP_DEC4; state_in = S_WGEN;
            end
         end
         S_WGEN: begin
            bcnt_in = 2'd3; phase_in = P_OUT; state_in = S_RI;
         end
         S_REJ: begin
            if (status.rej) begin
               state_in = S_WCHK;
            end else begin
               dp_cmd.op = OP_DIV_MOD; state_in = S_MODWAIT;
            end
         end
         S_LIMWAIT: if (!status.div_busy) state_in = S_WCHK;
         S_MODWAIT: begin
            if (!status.div_busy) begin
               dp_cmd.op = OP_RES_REM; state_in = S_DONE;
            end
         end
         S_KEND: begin
            dp_cmd.op = OP_KEY_CLR; state_in = S_RZ;
         end
         S_RZ: begin
            dp_cmd.op = OP_RES_ZERO; state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               done = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      bcnt_ff  <= bcnt_in;
      phase_ff <= phase_in;
      ret_ff   <= ret_in;
      kmode_ff <= kmode_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);
endmodule

// File: hw/rtl/rc4_random_generator.sv
// RC4 random generator top level: stream ports, register port, output register.
// Results come quickest for unused commands and bounds below 2, then a key byte, a byte,
// a word and a bounded value; a stir adds to this, the first one more as it fills the table.
// A final key byte adds its mixing pass and each rejected word adds a fresh word draw.
// One transaction at a time; the next is taken the cycle after its result is registered.
// Reset clears indices, countdown, flags and key count; the table is filled at first stir.
module rc4_random_generator
   import rc4rg_pkg::*;
#(
   parameter int KEY_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cmd[2:0], key_byte[10:3], bound_limit[42:11], zeros
   input  logic        req_tlast,  // key_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // value[31:0]
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [2:0]  cmd_ff;
   logic [7:0]  kb_ff;
   logic        last_ff;
   logic [31:0] bound_ff;
   logic        start_ff;
   logic [23:0] reseed_ff;
   logic [31:0] seed_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          idle, done, req_fire, csr_wr;
   logic [31:0]   result;
   logic [1:0]    csr_idx;

   assign req_tready = idle && !start_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign pready     = 1'b1;
   assign csr_wr     = psel && penable && pwrite;
   assign csr_idx    = {1'b0, paddr[2]};

   always_comb begin
      unique case (csr_idx)
         CSR_RESEED: prdata = {8'd0, reseed_ff};
         CSR_SEED:   prdata = seed_ff;
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tdata[2:0];
         kb_ff    <= req_tdata[10:3];
         bound_ff <= req_tdata[42:11];
         last_ff  <= req_tlast;
      end
      if (done) begin
         rsp_data_ff <= result;
      end
      if (reset) begin
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reseed_ff    <= RESEED_RESET;
         seed_ff      <= '0;
      end else begin
         start_ff <= req_fire;
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr && csr_idx == CSR_RESEED) reseed_ff <= pwdata[23:0];
         if (csr_wr && csr_idx == CSR_SEED)   seed_ff   <= pwdata;
      end
   end

   rc4rg_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .cmd      (cmd_ff),
      .key_last (last_ff),
      .out_free (!rsp_valid_ff || rsp_tready),
      .status   (dp_status),
      .dp_cmd   (dp_cmd),
      .idle     (idle),
      .done     (done)
   );

   rc4rg_datapath #(.KEY_BYTES(KEY_BYTES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .key_byte        (kb_ff),
      .bound_limit     (bound_ff),
      .reseed_interval (reseed_ff),
      .stir_seed       (seed_ff),
      .status          (dp_status),
      .result          (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
